// ----- rtl/sre_pkg.sv -----
// sre_pkg: shared constants, register indexes and the symbol table lookup
// for the signed radix digit emitter
// no dependencies
package sre_pkg;

  // default sizes for the top-level parameters
  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed field widths
  localparam int SYMBOL_W      = 8;
  localparam int DIGIT_W       = 4;
  localparam int RADIX_W       = 5;
  localparam int TABLE_SYMBOLS = 16;
  localparam int TABLE_W       = TABLE_SYMBOLS * SYMBOL_W;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 2;

  // quotient bits resolved per divider cycle
  localparam int DIV_BITS_PER_CYCLE = 8;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_LENGTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  // reserved characters
  localparam logic [SYMBOL_W-1:0] MINUS_SIGN = 8'h2D;
  localparam logic [SYMBOL_W-1:0] PLUS_SIGN  = 8'h2B;
  localparam logic [SYMBOL_W-1:0] NUL_BYTE   = 8'h00;

  // byte idx of the packed symbol table
  function automatic logic [SYMBOL_W-1:0] sym_at(input logic [TABLE_W-1:0] tbl,
                                                 input logic [DIGIT_W-1:0] idx);
    sym_at = tbl[{idx, 3'b000} +: SYMBOL_W];
  endfunction

endpackage

// ----- rtl/sre_ram.sv -----
// sre_ram: generic single-write, single-read RAM with registered read data
// depends on sre_pkg for default sizes
module sre_ram
  import sre_pkg::*;
#(
  parameter int WIDTH = DIGIT_W,
  parameter int DEPTH = VALUE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sre_div.sv -----
// sre_div: iterative divider of an unsigned value by a small radix,
// several restoring steps per cycle; depends on sre_pkg
module sre_div
  import sre_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [RADIX_W-1:0]     radix,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [DIGIT_W-1:0]     remainder
);

  localparam int CYCLES = (VALUE_WIDTH + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
  localparam int PAD_W  = CYCLES * DIV_BITS_PER_CYCLE;
  localparam int CYC_W  = $clog2(CYCLES + 1);

  logic [PAD_W-1:0]   shreg;
  logic [PAD_W-1:0]   shreg_next;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] rem_next;
  logic [CYC_W-1:0]   left;

  // dividend bits shift out the top, quotient bits shift in the bottom
  always_comb begin
    logic [RADIX_W-1:0] t;
    logic               ge;
    shreg_next = shreg;
    rem_next   = rem;
    for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
      t          = {rem_next, shreg_next[PAD_W-1]};
      ge         = (t >= radix);
      shreg_next = {shreg_next[PAD_W-2:0], ge};
      rem_next   = ge ? DIGIT_W'(t - radix) : t[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        shreg <= PAD_W'(dividend);
        rem   <= '0;
        left  <= CYC_W'(CYCLES);
      end else if (left != '0) begin
        shreg <= shreg_next;
        rem   <= rem_next;
        left  <= left - CYC_W'(1);
        if (left == CYC_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = shreg[VALUE_WIDTH-1:0];
  assign remainder = rem;

endmodule

// ----- rtl/signed_radix_digit_emitter_top.sv -----
// signed_radix_digit_emitter_top: converts a signed value to symbol bytes in a
// configurable radix; depends on sre_pkg, sre_div and sre_ram
//
//   channel  direction  signals                         payload
//   in       sink       in_valid / in_ready             value
//   out      source     out_valid / out_ready           symbol, last
//   cfg      sink       cfg_valid / cfg_ready           cfg_index, cfg_data
//
// one item at a time: after the accept the symbol table is checked symbol by
// symbol, then the sign is handled and the divider is started; each digit comes
// from the shared divider, and the digits are then emitted most significant
// first through the registered digit stack read; a zero value skips the divider
// sync reset clears the config registers, so the base reads invalid until set
// out_ready low stalls emission in place; cfg_ready is always high
module signed_radix_digit_emitter_top
  import sre_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] value,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SYMBOL_W-1:0]           symbol,
  output logic                          last,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int IDX_W  = $clog2(MAX_SYMBOLS);
  localparam int ADDR_W = $clog2(VALUE_WIDTH);
  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SIGN,
    S_ZERO,
    S_DIV_START,
    S_DIV_WAIT,
    S_READ,
    S_FETCH
  } state_t;

  state_t state;

  // configuration registers
  logic [RADIX_W-1:0]    base_length;
  logic [CFG_DATA_W-1:0] symbols_low;
  logic [CFG_DATA_W-1:0] symbols_high;
  logic [TABLE_W-1:0]    tbl;

  // per-item registers
  logic                   neg;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic [IDX_W-1:0]       idx;
  logic [CNT_W-1:0]       digit_count;

  // divider and stack wiring
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quotient;
  logic [DIGIT_W-1:0]     div_remainder;
  logic                   stack_we;
  logic [ADDR_W-1:0]      stack_raddr;
  logic [DIGIT_W-1:0]     stack_rdata;

  // table check of the symbol at idx
  logic [SYMBOL_W-1:0] cur_sym;
  logic                len_bad;
  logic                sym_bad;
  logic                dup;
  logic                idx_last;

  logic slot_free;
  logic in_fire;
  logic emit;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign tbl       = {symbols_high, symbols_low};

  // a symbol goes into the output register this cycle
  assign emit = slot_free &&
                (((state == S_SIGN) && neg) || (state == S_ZERO) || (state == S_FETCH));

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length  <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_LENGTH:  base_length  <= cfg_data[RADIX_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // one symbol per cycle against every later symbol in use
  always_comb begin
    cur_sym  = sym_at(tbl, DIGIT_W'(idx));
    len_bad  = (base_length < RADIX_W'(2)) || (base_length > RADIX_W'(MAX_SYMBOLS));
    sym_bad  = (cur_sym == NUL_BYTE) || (cur_sym == MINUS_SIGN) || (cur_sym == PLUS_SIGN);
    idx_last = (RADIX_W'(idx) == base_length - RADIX_W'(1));
    dup      = 1'b0;
    for (int j = 0; j < TABLE_SYMBOLS; j++) begin
      if ((RADIX_W'(j) > RADIX_W'(idx)) && (RADIX_W'(j) < base_length) &&
          (sym_at(tbl, DIGIT_W'(j)) == cur_sym)) begin
        dup = 1'b1;
      end
    end
  end

  // back-to-back digits: restart the divider straight from its quotient
  assign div_start    = (state == S_DIV_START) ||
                        ((state == S_DIV_WAIT) && div_done && (div_quotient != '0));
  assign div_dividend = (state == S_DIV_START) ? magnitude : div_quotient;
  assign stack_we     = (state == S_DIV_WAIT) && div_done;
  assign stack_raddr  = ADDR_W'(digit_count - CNT_W'(1));

  sre_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .radix     (base_length),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // digits pushed least significant first, popped most significant first
  sre_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_WIDTH)
  ) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (digit_count[ADDR_W-1:0]),
    .wdata (div_remainder),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      neg         <= 1'b0;
      magnitude   <= '0;
      idx         <= '0;
      digit_count <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            neg       <= value[VALUE_WIDTH-1];
            // two's complement magnitude, exact for the most negative value
            magnitude <= value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
            idx       <= '0;
            state     <= S_CHECK;
          end
        end

        S_CHECK: begin
          priority if (len_bad || sym_bad || dup) begin
            state <= S_IDLE;  // invalid base, item dropped
          end else if (idx_last) begin
            state <= S_SIGN;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end

        S_SIGN: begin
          digit_count <= '0;
          priority if (neg) begin
            if (slot_free) begin
              symbol    <= MINUS_SIGN;
              last      <= 1'b0;
              state     <= S_DIV_START;
            end
          end else if (magnitude == '0) begin
            state <= S_ZERO;
          end else begin
            state <= S_DIV_START;
          end
        end

        S_ZERO: begin
          if (slot_free) begin
            symbol    <= sym_at(tbl, '0);
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end

        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_done) begin
            digit_count <= digit_count + CNT_W'(1);
            if (div_quotient == '0) begin
              state <= S_READ;
            end
          end
        end

        S_READ: begin
          // stack read data lands next cycle
          state <= S_FETCH;
        end

        S_FETCH: begin
          if (slot_free) begin
            symbol      <= sym_at(tbl, stack_rdata);
            last        <= (digit_count == CNT_W'(1));
            digit_count <= digit_count - CNT_W'(1);
            state       <= (digit_count == CNT_W'(1)) ? S_IDLE : S_READ;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
